### hdl/sts_pkg.sv
// Shared types and codes for the sorted table search and insert core.
// Used by the channel interfaces and by the top level; depends on nothing.
package sts_pkg;

	localparam int MODE_W = 2;
	localparam int KEY_W  = 32;
	localparam int IDX_W  = 6;
	localparam int POS_W  = 7;
	localparam int STAT_W = 2;
	localparam int CNT_W  = 7;

	typedef logic [MODE_W-1:0] mode_t;
	typedef logic [KEY_W-1:0]  key_t;
	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [POS_W-1:0]  pos_t;
	typedef logic [STAT_W-1:0] stat_t;
	typedef logic [CNT_W-1:0]  cnt_t;

	localparam mode_t MODE_FIND   = 2'd0;
	localparam mode_t MODE_INSERT = 2'd1;
	localparam mode_t MODE_ERASE  = 2'd2;

	localparam stat_t STAT_OK    = 2'd0;
	localparam stat_t STAT_FULL  = 2'd1;
	localparam stat_t STAT_RANGE = 2'd2;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SEARCH,
		S_CMP,
		S_PLACE,
		S_SHUP,
		S_WKEY,
		S_SHDN,
		S_DONE
	} state_t;

endpackage

### hdl/sts_if.sv
// Valid/ready channel interfaces for operation beats and result beats.
// Depends on sts_pkg for the payload types.
interface sts_op_if;
	logic             valid;
	logic             ready;
	sts_pkg::mode_t   mode;
	sts_pkg::key_t    key;
	sts_pkg::idx_t    index;

	modport source (output valid, output mode, output key, output index, input ready);
	modport sink   (input valid, input mode, input key, input index, output ready);
endinterface

interface sts_res_if;
	logic             valid;
	logic             ready;
	sts_pkg::pos_t    position;
	logic             found;
	sts_pkg::stat_t   status;
	sts_pkg::cnt_t    count;

	modport source (output valid, output position, output found, output status,
		output count, input ready);
	modport sink   (input valid, input position, input found, input status,
		input count, output ready);
endinterface

### hdl/sorted_table_search_insert_core.sv
// Sorted key table with binary search, ordered insert and erase by index.
// Depends on sts_pkg and on the sts_op_if / sts_res_if channel interfaces.
//
// Usage: each beat on the op channel is one operation (find, insert or
// erase); each produces exactly one beat on the res channel with position,
// found flag, status and the entry count after the operation. The cfg_we /
// cfg_wdata port sets signed (1) or unsigned (0) key compares; write it only
// while no operation is in flight.
// One operation is handled at a time; op.ready is high only when idle.
// All work goes through one table memory with a registered read port and one
// key comparator. A find runs a binary search, one probe at a time; an insert
// runs the same search, moves the n - position entries at and above its place
// up by one and writes the key; an erase moves the n - index - 1 entries above
// the index down by one. The result sits in an output register; the next
// operation can be accepted in the cycle after the result is loaded, but a
// finished operation holds in its last state until the receiver takes the
// previous result.
// Reset clears the count (the table contents need no clearing) and selects
// signed compares; the block is ready straight out of reset.
module sorted_table_search_insert_core #(
	parameter int DEPTH     = 64,
	parameter int KEY_WIDTH = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_wdata,
	sts_op_if.sink            op,
	sts_res_if.source         res
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int XW = ((CW > sts_pkg::IDX_W) ? CW : sts_pkg::IDX_W) + 1;
	localparam logic [KEY_WIDTH-1:0] SIGN_BIT = KEY_WIDTH'(1) << (KEY_WIDTH - 1);

	sts_pkg::state_t state_q, state_d;

	logic [CW-1:0]        cnt_q, cnt_d;
	logic                 sgn_q;
	logic                 res_vld_q, res_vld_d;
	logic                 res_ld;

	sts_pkg::mode_t       mode_q, mode_d;
	logic [KEY_WIDTH-1:0] key_q, key_d;
	logic [CW-1:0]        lo_q, lo_d;
	logic [CW-1:0]        hix_q, hix_d;
	logic [AW-1:0]        mid_q, mid_d;
	logic [CW-1:0]        wr_q, wr_d;
	sts_pkg::pos_t        pos_q, pos_d;
	logic                 hit_q, hit_d;
	sts_pkg::stat_t       st_q, st_d;

	sts_pkg::pos_t        res_pos_q;
	logic                 res_found_q;
	sts_pkg::stat_t       res_st_q;
	sts_pkg::cnt_t        res_cnt_q;

	logic [KEY_WIDTH-1:0] mem_q [DEPTH];
	logic [KEY_WIDTH-1:0] rd_q;
	logic                 mem_we;
	logic [AW-1:0]        mem_waddr;
	logic [AW-1:0]        mem_raddr;
	logic [KEY_WIDTH-1:0] mem_wdata;

	logic [CW:0]          mid_sum;
	logic [KEY_WIDTH-1:0] cmp_a, cmp_b;
	logic                 cmp_lt, cmp_eq;
	logic [XW-1:0]        idx_x, cnt_x;

	// Shared comparator: flipping the sign bit turns an unsigned compare into
	// a signed one.
	assign cmp_a  = key_q ^ (sgn_q ? SIGN_BIT : '0);
	assign cmp_b  = rd_q ^ (sgn_q ? SIGN_BIT : '0);
	assign cmp_lt = cmp_a < cmp_b;
	assign cmp_eq = cmp_a == cmp_b;

	// hix_q is one past the upper bound, so the probe is floor((lo+hi)/2).
	assign mid_sum = {1'b0, lo_q} + {1'b0, hix_q} - (CW+1)'(1);

	assign idx_x = XW'(op.index);
	assign cnt_x = XW'(cnt_q);

	assign op.ready     = (state_q == sts_pkg::S_IDLE);
	assign res.valid    = res_vld_q;
	assign res.position = res_pos_q;
	assign res.found    = res_found_q;
	assign res.status   = res_st_q;
	assign res.count    = res_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= sts_pkg::S_IDLE;
			cnt_q     <= '0;
			sgn_q     <= 1'b1;
			res_vld_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			cnt_q     <= cnt_d;
			res_vld_q <= res_vld_d;
			if (cfg_we) begin
				sgn_q <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		mode_q <= mode_d;
		key_q  <= key_d;
		lo_q   <= lo_d;
		hix_q  <= hix_d;
		mid_q  <= mid_d;
		wr_q   <= wr_d;
		pos_q  <= pos_d;
		hit_q  <= hit_d;
		st_q   <= st_d;
		if (res_ld) begin
			res_pos_q   <= pos_q;
			res_found_q <= hit_q;
			res_st_q    <= st_q;
			res_cnt_q   <= sts_pkg::cnt_t'(cnt_q);
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr] <= mem_wdata;
		end
		rd_q <= mem_q[mem_raddr];
	end

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		mode_d    = mode_q;
		key_d     = key_q;
		lo_d      = lo_q;
		hix_d     = hix_q;
		mid_d     = mid_q;
		wr_d      = wr_q;
		pos_d     = pos_q;
		hit_d     = hit_q;
		st_d      = st_q;
		res_ld    = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = key_q;
		mem_raddr = '0;

		unique case (state_q)
			sts_pkg::S_IDLE: begin
				if (op.valid) begin
					mode_d = op.mode;
					key_d  = KEY_WIDTH'(op.key);
					lo_d   = '0;
					hix_d  = cnt_q;
					hit_d  = 1'b0;
					st_d   = sts_pkg::STAT_OK;
					pos_d  = '0;
					unique case (op.mode)
						sts_pkg::MODE_FIND, sts_pkg::MODE_INSERT: begin
							state_d = sts_pkg::S_SEARCH;
						end
						sts_pkg::MODE_ERASE: begin
							pos_d = sts_pkg::pos_t'(op.index);
							if (idx_x >= cnt_x) begin
								st_d    = sts_pkg::STAT_RANGE;
								state_d = sts_pkg::S_DONE;
							end else if (idx_x + XW'(1) < cnt_x) begin
								mem_raddr = AW'(idx_x + XW'(1));
								wr_d      = CW'(op.index);
								state_d   = sts_pkg::S_SHDN;
							end else begin
								cnt_d   = cnt_q - CW'(1);
								state_d = sts_pkg::S_DONE;
							end
						end
						default: begin
							state_d = sts_pkg::S_DONE;
						end
					endcase
				end
			end

			sts_pkg::S_SEARCH: begin
				if (lo_q < hix_q) begin
					mem_raddr = mid_sum[AW:1];
					mid_d     = mid_sum[AW:1];
					state_d   = sts_pkg::S_CMP;
				end else begin
					pos_d   = sts_pkg::pos_t'(lo_q);
					state_d = sts_pkg::S_PLACE;
				end
			end

			sts_pkg::S_CMP: begin
				if (cmp_eq) begin
					hit_d   = 1'b1;
					pos_d   = sts_pkg::pos_t'(mid_q);
					lo_d    = CW'(mid_q);
					state_d = sts_pkg::S_PLACE;
				end else if (cmp_lt) begin
					hix_d   = CW'(mid_q);
					state_d = sts_pkg::S_SEARCH;
				end else begin
					lo_d    = CW'(mid_q) + CW'(1);
					state_d = sts_pkg::S_SEARCH;
				end
			end

			// lo_q now holds the match or insert position.
			sts_pkg::S_PLACE: begin
				if (mode_q != sts_pkg::MODE_INSERT) begin
					state_d = sts_pkg::S_DONE;
				end else if (cnt_q >= CW'(DEPTH)) begin
					st_d    = sts_pkg::STAT_FULL;
					state_d = sts_pkg::S_DONE;
				end else if (cnt_q > lo_q) begin
					mem_raddr = AW'(cnt_q - CW'(1));
					wr_d      = cnt_q;
					state_d   = sts_pkg::S_SHUP;
				end else begin
					state_d = sts_pkg::S_WKEY;
				end
			end

			// Each cycle writes the entry read in the previous cycle one place
			// up and reads the next one below it.
			sts_pkg::S_SHUP: begin
				mem_we    = 1'b1;
				mem_waddr = wr_q[AW-1:0];
				mem_wdata = rd_q;
				if (wr_q - CW'(1) > lo_q) begin
					mem_raddr = AW'(wr_q - CW'(2));
					wr_d      = wr_q - CW'(1);
				end else begin
					state_d = sts_pkg::S_WKEY;
				end
			end

			sts_pkg::S_WKEY: begin
				mem_we    = 1'b1;
				mem_waddr = lo_q[AW-1:0];
				mem_wdata = key_q;
				cnt_d     = cnt_q + CW'(1);
				state_d   = sts_pkg::S_DONE;
			end

			sts_pkg::S_SHDN: begin
				mem_we    = 1'b1;
				mem_waddr = wr_q[AW-1:0];
				mem_wdata = rd_q;
				if ({1'b0, wr_q} + (CW+1)'(2) < {1'b0, cnt_q}) begin
					mem_raddr = AW'(wr_q + CW'(2));
					wr_d      = wr_q + CW'(1);
				end else begin
					cnt_d   = cnt_q - CW'(1);
					state_d = sts_pkg::S_DONE;
				end
			end

			sts_pkg::S_DONE: begin
				if (!res_vld_q || res.ready) begin
					res_ld  = 1'b1;
					state_d = sts_pkg::S_IDLE;
				end
			end

			default: begin
				state_d = sts_pkg::S_IDLE;
			end
		endcase

		if (res_ld) begin
			res_vld_d = 1'b1;
		end else if (res.ready) begin
			res_vld_d = 1'b0;
		end else begin
			res_vld_d = res_vld_q;
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("entry count exceeds table depth");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		op.valid && op.ready |=> !op.ready)
		else $error("operation accepted while another is in flight");

	a_res_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res.valid) |-> $past(state_q == sts_pkg::S_DONE))
		else $error("result raised outside the completion state");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == sts_pkg::S_WKEY |=> cnt_q == $past(cnt_q) + CW'(1))
		else $error("insert did not grow the count by one");

	a_probe_in_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == sts_pkg::S_CMP |-> (CW'(mid_q) < hix_q) && (lo_q <= CW'(mid_q)))
		else $error("search probe outside its bounds");

endmodule

### sim/sorted_table_checker.sv
// Checker for the sorted table core: watches the register port and both channels,
// keeps its own copy of the key table and compares every result beat.
// Depends on sts_pkg and on the sts_op_if / sts_res_if interfaces.
module sorted_table_checker #(
	parameter int DEPTH = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic cfg_wdata,
	sts_op_if    op_ch,
	sts_res_if   res_ch,
	output int   fail_count,
	output int   pending,
	output int   table_count,
	output int   op_count,
	output int   hit_count,
	output int   full_count,
	output int   range_count
);

	typedef struct packed {
		sts_pkg::pos_t  position;
		logic           found;
		sts_pkg::stat_t status;
		sts_pkg::cnt_t  count;
	} outcome_t;

	sts_pkg::key_t keys [DEPTH];
	int       n_keys = 0;
	bit       signed_mode = 1'b1;
	outcome_t search_outcomes [$];
	int       fails = 0;
	int       ops = 0;
	int       hits = 0;
	int       fulls = 0;
	int       ranges = 0;

	function automatic bit key_below(sts_pkg::key_t a, sts_pkg::key_t b);
		if (signed_mode)
			return $signed(a) < $signed(b);
		return a < b;
	endfunction

	// Applies one operation to the local table and returns the result it must give.
	function automatic outcome_t table_apply(sts_pkg::mode_t m, sts_pkg::key_t k,
		sts_pkg::idx_t ix);
		outcome_t o;
		int       lo;
		int       hi;
		int       mid;
		int       p;
		int       i;
		logic     hit;
		o = '0;
		hit = 1'b0;
		lo = 0;
		hi = n_keys - 1;
		mid = 0;
		p = 0;
		if (m == sts_pkg::MODE_FIND || m == sts_pkg::MODE_INSERT) begin
			while (lo <= hi && !hit) begin
				mid = (lo + hi) / 2;
				if (k == keys[mid])
					hit = 1'b1;
				else if (key_below(k, keys[mid]))
					hi = mid - 1;
				else
					lo = mid + 1;
			end
			p = hit ? mid : lo;
			o.position = sts_pkg::pos_t'(p);
			o.found = hit;
		end
		case (m)
			sts_pkg::MODE_INSERT: begin
				if (n_keys >= DEPTH) begin
					o.status = sts_pkg::STAT_FULL;
				end else begin
					for (i = n_keys; i > p; i--)
						keys[i] = keys[i - 1];
					keys[p] = k;
					n_keys++;
				end
			end
			sts_pkg::MODE_ERASE: begin
				o.position = sts_pkg::pos_t'(ix);
				if (int'(ix) >= n_keys) begin
					o.status = sts_pkg::STAT_RANGE;
				end else begin
					for (i = int'(ix); i + 1 < n_keys; i++)
						keys[i] = keys[i + 1];
					n_keys--;
				end
			end
			default: begin
			end
		endcase
		o.count = sts_pkg::cnt_t'(n_keys);
		return o;
	endfunction

	always @(posedge clk) begin : watch
		outcome_t want;
		if (!arst_n) begin
			signed_mode = 1'b1;
			n_keys = 0;
		end else begin
			if (cfg_we)
				signed_mode = cfg_wdata;
			if (op_ch.valid && op_ch.ready) begin
				want = table_apply(op_ch.mode, op_ch.key, op_ch.index);
				search_outcomes.push_back(want);
				ops++;
				if (want.found)
					hits++;
				if (want.status == sts_pkg::STAT_FULL)
					fulls++;
				if (want.status == sts_pkg::STAT_RANGE)
					ranges++;
			end
			if (res_ch.valid && res_ch.ready) begin
				if (search_outcomes.size() == 0) begin
					$error("result beat arrived with no operation outstanding");
					fails++;
				end else begin
					want = search_outcomes.pop_front();
					if (res_ch.position !== want.position) begin
						$error("position: expected %0d, got %0d",
							want.position, res_ch.position);
						fails++;
					end
					if (res_ch.found !== want.found) begin
						$error("found: expected %0d, got %0d", want.found, res_ch.found);
						fails++;
					end
					if (res_ch.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, res_ch.status);
						fails++;
					end
					if (res_ch.count !== want.count) begin
						$error("count: expected %0d, got %0d", want.count, res_ch.count);
						fails++;
					end
				end
			end
		end
		// Exported with nonblocking updates so the stimulus side reads settled values.
		fail_count <= fails;
		pending <= search_outcomes.size();
		table_count <= n_keys;
		op_count <= ops;
		hit_count <= hits;
		full_count <= fulls;
		range_count <= ranges;
	end

endmodule

### sim/tb_sorted_table_search_insert_core.sv
// Top of the sorted table core testbench: clock, reset, operation stimulus,
// result back-pressure and the verdict. Depends on sts_pkg, the channel
// interfaces, the core and sorted_table_checker.
module tb_sorted_table_search_insert_core;

	localparam sts_pkg::mode_t MODE_UNUSED = 2'd3;
	localparam int    RANDOM_ITEMS = 1600;
	localparam int    PHASES       = 6;
	localparam int    CYCLE_LIMIT  = 1000000;
	localparam int    TAIL_CYCLES  = 100;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;
	bit   no_idle;
	int   cycles = 0;

	int fail_count;
	int pending;
	int table_count;
	int op_count;
	int hit_count;
	int full_count;
	int range_count;

	sts_op_if  op_ch ();
	sts_res_if res_ch ();

	sorted_table_search_insert_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.op        (op_ch),
		.res       (res_ch)
	);

	sorted_table_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.op_ch       (op_ch),
		.res_ch      (res_ch),
		.fail_count  (fail_count),
		.pending     (pending),
		.table_count (table_count),
		.op_count    (op_count),
		.hit_count   (hit_count),
		.full_count  (full_count),
		.range_count (range_count)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d results outstanding", cycles, pending);
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Keys lean on sign-boundary values and a small pool so that duplicates
	// and signed/unsigned ordering differences show up often.
	function automatic sts_pkg::key_t pick_key();
		sts_pkg::key_t k;
		case ($urandom_range(9, 0))
			0, 1: begin
				case ($urandom_range(5, 0))
					0: k = 32'h0000_0000;
					1: k = 32'hffff_ffff;
					2: k = 32'h7fff_ffff;
					3: k = 32'h8000_0000;
					4: k = 32'h0000_0001;
					default: k = 32'h8000_0001;
				endcase
			end
			2, 3, 4: begin
				k = $urandom_range(15, 0);
				if ($urandom_range(1, 0) == 1)
					k = k | 32'hffff_fff0;
			end
			default: k = $urandom;
		endcase
		return k;
	endfunction

	function automatic sts_pkg::mode_t pick_mode(int ins_w, int era_w);
		int r;
		r = $urandom_range(99, 0);
		if (r == 99)
			return MODE_UNUSED;
		if (r < ins_w)
			return sts_pkg::MODE_INSERT;
		if (r < ins_w + era_w)
			return sts_pkg::MODE_ERASE;
		return sts_pkg::MODE_FIND;
	endfunction

	// Presents one operation beat and returns at the edge where it is taken.
	task automatic send_op(input sts_pkg::mode_t m, input sts_pkg::key_t k,
		input sts_pkg::idx_t ix);
		int gap;
		gap = no_idle ? 0 : $urandom_range(3, 0);
		if (gap != 0) begin
			op_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		op_ch.valid <= 1'b1;
		op_ch.mode <= m;
		op_ch.key <= k;
		op_ch.index <= ix;
		do @(posedge clk); while (!op_ch.ready);
	endtask

	task automatic wait_idle();
		op_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic write_cfg(input logic signed_keys);
		cfg_we <= 1'b1;
		cfg_wdata <= signed_keys;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Empties the table so the next compare mode starts from a sorted state.
	task automatic drain_table();
		wait_idle();
		while (table_count != 0) begin
			send_op(sts_pkg::MODE_ERASE, $urandom,
				sts_pkg::idx_t'($urandom_range(table_count - 1, 0)));
			wait_idle();
		end
	endtask

	initial begin
		int stall;
		stall = 0;
		res_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (res_ch.valid && res_ch.ready)
				stall = no_idle ? 0 : $urandom_range(3, 0);
			else if (stall > 0)
				stall--;
			res_ch.ready <= arst_n && (stall == 0);
		end
	end

	initial begin
		int             ph;
		int             n;
		int             ins_w;
		int             era_w;
		sts_pkg::mode_t m;
		sts_pkg::idx_t  ix;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		no_idle = 1'b0;
		op_ch.valid = 1'b0;
		op_ch.mode = sts_pkg::MODE_FIND;
		op_ch.key = '0;
		op_ch.index = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_cfg(1'b1);

		// Empty table, ordered inserts across the sign boundary, duplicates,
		// hits and misses, the unused mode and erases at and past the end.
		send_op(sts_pkg::MODE_FIND, 32'h0000_0000, 6'd0);
		send_op(sts_pkg::MODE_ERASE, 32'hffff_ffff, 6'd0);
		send_op(sts_pkg::MODE_ERASE, 32'h0000_0000, 6'd63);
		send_op(sts_pkg::MODE_INSERT, 32'h7fff_ffff, 6'd63);
		send_op(sts_pkg::MODE_INSERT, 32'h8000_0000, 6'd0);
		send_op(sts_pkg::MODE_INSERT, 32'hffff_ffff, 6'd0);
		send_op(sts_pkg::MODE_INSERT, 32'h0000_0000, 6'd0);
		send_op(sts_pkg::MODE_INSERT, 32'h0000_0000, 6'd0);
		send_op(sts_pkg::MODE_INSERT, 32'h8000_0000, 6'd0);
		send_op(sts_pkg::MODE_FIND, 32'h0000_0000, 6'd0);
		send_op(sts_pkg::MODE_FIND, 32'hffff_ffff, 6'd63);
		send_op(sts_pkg::MODE_FIND, 32'h1234_5678, 6'd0);
		send_op(sts_pkg::MODE_FIND, 32'h8000_0001, 6'd0);
		send_op(MODE_UNUSED, 32'hffff_ffff, 6'd63);
		send_op(sts_pkg::MODE_ERASE, 32'h0000_0000, 6'd0);
		send_op(sts_pkg::MODE_ERASE, 32'h0000_0000, 6'd4);
		send_op(sts_pkg::MODE_ERASE, 32'h0000_0000, 6'd63);
		send_op(sts_pkg::MODE_ERASE, 32'h0000_0000, 6'd4);
		send_op(sts_pkg::MODE_FIND, 32'h7fff_ffff, 6'd0);

		for (ph = 0; ph < PHASES; ph++) begin
			// One mode change keeps the old contents, so a table sorted the
			// other way is searched as well.
			if (ph != 3)
				drain_table();
			else
				wait_idle();
			repeat (4) @(posedge clk);
			write_cfg(ph % 2 == 1);
			case (ph % 3)
				0: begin
					ins_w = 60;
					era_w = 15;
				end
				1: begin
					ins_w = 33;
					era_w = 33;
				end
				default: begin
					ins_w = 20;
					era_w = 55;
				end
			endcase
			for (n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
				if (n % 40 == 0)
					no_idle <= ($urandom_range(3, 0) == 0);
				if (ph == 1 && n == 130)
					wait_idle();
				m = pick_mode(ins_w, era_w);
				if (m == sts_pkg::MODE_ERASE && table_count > 0 && $urandom_range(4, 0) != 0)
					ix = sts_pkg::idx_t'($urandom_range(table_count - 1, 0));
				else
					ix = sts_pkg::idx_t'($urandom_range(63, 0));
				send_op(m, pick_key(), ix);
			end
		end

		wait_idle();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Ran %0d operations over %0d compare-mode phases, signed and unsigned.",
			op_count, PHASES + 1);
		$display("Searches hit %0d times, %0d inserts met a full table, %0d erases were out of range.",
			hit_count, full_count, range_count);
		if (fail_count == 0 && pending == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
